@@ sv/box_blur_3x3_clipped_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the clipped 3x3 box blur
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_CLIPPED_ASSERT_SVH
`define BOX_BLUR_3X3_CLIPPED_ASSERT_SVH

// Condition must hold at every clock edge out of reset
`define BB3C_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition in one cycle forces the consequence in the next
`define BB3C_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bb3c_pkg.sv @@
// ----------------------------------------------------------------------------
// bb3c_pkg
// Types, constants and the reciprocal table of the clipped 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3c_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_SIZE_DEF     = 1024;
	localparam int CHANNEL_BITS_DEF = 16;

	// Fixed port widths
	localparam int CH_W       = 16;
	localparam int POS_OUT_W  = 10;
	localparam int SIZE_W     = 11;
	localparam int SIZE_RESET = 1024;

	// Divide by window size: multiply by floor(2^RECIP_SHIFT / d), then correct
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int DIV_W       = 4;

	// Result queue depth (power of two)
	localparam int QDEPTH = 8;

	typedef struct packed {
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0]      out_red;
		logic [CH_W-1:0]      out_green;
		logic [CH_W-1:0]      out_blue;
		logic [POS_OUT_W-1:0] out_row;
		logic [POS_OUT_W-1:0] out_col;
		logic                 last_of_run;
	} pix_out_t;

	// Reciprocals of the possible window sizes (9, 6, 4, 3, 2, 1)
	function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] div);
		logic [RECIP_W-1:0] m;
		case (div)
			DIV_W'(9): m = RECIP_W'(1864135);
			DIV_W'(6): m = RECIP_W'(2796202);
			DIV_W'(4): m = RECIP_W'(4194304);
			DIV_W'(3): m = RECIP_W'(5592405);
			DIV_W'(2): m = RECIP_W'(8388608);
			default:   m = RECIP_W'(16777216);
		endcase
		return m;
	endfunction

endpackage

@@ sv/box_blur_3x3_clipped.sv @@
// ----------------------------------------------------------------------------
// box_blur_3x3_clipped
// Streaming 3x3 box blur of a square RGB image with clipped borders.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per transfer; each result is the truncated
// mean of the window rows i..i+2, columns j..j+2 that lie inside the image,
// sent with its coordinates as soon as its last pixel has arrived. A pixel that
// closes at most one result is taken every clock while the result queue has
// room. The result generator issues one result per clock, also only while the
// queue has room, so a pixel at a row end or the image end holds the input
// until its last result issues. A pixel's path runs through the line memory read,
// window update, row sums, window sum and reciprocal multiply, then the
// rounding fix into an 8-entry result queue, which also decouples output stalls.
// Rows r-1 and r-2 live in one line memory, read for column c when the pixel
// is taken and written back for that column as it enters the window. Writing
// image_size restarts at pixel (0,0); do so only while the block is idle.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_clipped_assert.svh"

module box_blur_3x3_clipped
	import bb3c_pkg::*;
#(
	parameter int MAX_SIZE     = MAX_SIZE_DEF,
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  pix_in_t           pix,
	output logic              res_valid,
	input  logic              res_ready,
	output pix_out_t          res,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata
);

	localparam int POS_W     = $clog2(MAX_SIZE);
	localparam int PIX_W     = 3 * CHANNEL_BITS;
	localparam int ENTRY_W   = 2 * PIX_W;
	localparam int ROW_W     = CHANNEL_BITS + 2;
	localparam int SUM_W     = CHANNEL_BITS + 4;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam int CLAMP_W   = SIZE_W + 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = QPTR_W + 1;
	localparam int SIZE_INIT = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;

	typedef logic [2:0][CHANNEL_BITS-1:0] rgb_t;

	// ------------------------------------------------------------------
	// Configuration and position counters
	// ------------------------------------------------------------------
	logic [CLAMP_W-1:0] size_ext, size_clamp;
	logic [POS_W-1:0]   last_q, row_q, col_q;
	logic               acc;

	always_comb begin
		size_ext = CLAMP_W'(cfg_wdata);
		if (size_ext == '0) begin
			size_clamp = CLAMP_W'(1);
		end else if (size_ext > CLAMP_W'(MAX_SIZE)) begin
			size_clamp = CLAMP_W'(MAX_SIZE);
		end else begin
			size_clamp = size_ext;
		end
	end

	assign acc = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= POS_W'(SIZE_INIT - 1);
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_we) begin
			last_q <= POS_W'(size_clamp - CLAMP_W'(1));
			row_q  <= '0;
			col_q  <= '0;
		end else if (acc) begin
			if (col_q == last_q) begin
				col_q <= '0;
				row_q <= (row_q == last_q) ? '0 : row_q + POS_W'(1);
			end else begin
				col_q <= col_q + POS_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Line memory: {row r-1, row r-2} per column
	// ------------------------------------------------------------------
	logic [ENTRY_W-1:0] line_mem [MAX_SIZE];
	logic [ENTRY_W-1:0] rd_data_q, fwd_data_q, entry_s1, mem_wdata;
	logic [POS_W-1:0]   mem_waddr;
	logic               mem_we, fwd_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[mem_waddr] <= mem_wdata;
		end
		if (acc) begin
			rd_data_q  <= line_mem[col_q];
			fwd_data_q <= mem_wdata;
		end
	end

	// read and write of one column in the same cycle: take the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (acc) begin
			fwd_q <= mem_we && (mem_waddr == col_q);
		end
	end

	assign entry_s1 = fwd_q ? fwd_data_q : rd_data_q;

	// ------------------------------------------------------------------
	// Stage 1: accepted pixel waiting for the window
	// ------------------------------------------------------------------
	rgb_t             px_in, px_s1;
	logic [POS_W-1:0] row_s1, col_s1;
	logic             s1_v_q, advance;

	assign px_in[0] = pix.in_red[CHANNEL_BITS-1:0];
	assign px_in[1] = pix.in_green[CHANNEL_BITS-1:0];
	assign px_in[2] = pix.in_blue[CHANNEL_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (acc) begin
			s1_v_q <= 1'b1;
		end else if (advance) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1  <= px_in;
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
	end

	// write back: current pixel becomes row r-1, old row r-1 becomes row r-2
	assign mem_we    = advance;
	assign mem_waddr = col_s1;
	assign mem_wdata = {px_s1, entry_s1[ENTRY_W-1:PIX_W]};

	// ------------------------------------------------------------------
	// Window and result generator
	// ------------------------------------------------------------------
	// win_q[k][w]: k = 0 row r-2, 1 row r-1, 2 row r; w = 0 column c-2 .. 2 column c
	rgb_t             win_q [3][3];
	logic [POS_W-1:0] row2_q, col2_q;
	logic [1:0]       a_q, b_q, b_lo_q, a_hi_q, b_hi_q;
	logic [1:0]       a_lo, a_hi, b_lo, b_hi;
	logic             gen_busy_q, issue, gen_last, ranges_ok;
	logic [QCNT_W-1:0] occ_q;

	// first and last window offsets of the results that this pixel closes
	always_comb begin
		a_lo = (row_s1 == '0) ? 2'd2 : ((row_s1 == POS_W'(1)) ? 2'd1 : 2'd0);
		b_lo = (col_s1 == '0) ? 2'd2 : ((col_s1 == POS_W'(1)) ? 2'd1 : 2'd0);
		a_hi = (row_s1 == last_q) ? 2'd2 : 2'd0;
		b_hi = (col_s1 == last_q) ? 2'd2 : 2'd0;
		ranges_ok = (a_lo <= a_hi) && (b_lo <= b_hi);
	end

	assign issue     = gen_busy_q && (occ_q < QCNT_W'(QDEPTH));
	assign gen_last  = (a_q == a_hi_q) && (b_q == b_hi_q);
	assign advance   = s1_v_q && (!gen_busy_q || (issue && gen_last));
	assign pix_ready = !s1_v_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_busy_q <= 1'b0;
		end else if (advance) begin
			gen_busy_q <= ranges_ok;
		end else if (issue && gen_last) begin
			gen_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			if (b_q == b_hi_q) begin
				b_q <= b_lo_q;
				a_q <= a_q + 2'd1;
			end else begin
				b_q <= b_q + 2'd1;
			end
		end
		if (advance) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= entry_s1[PIX_W-1:0];
			win_q[1][2] <= entry_s1[ENTRY_W-1:PIX_W];
			win_q[2][2] <= px_s1;
			row2_q <= row_s1;
			col2_q <= col_s1;
			a_q    <= a_lo;
			b_q    <= b_lo;
			b_lo_q <= b_lo;
			a_hi_q <= a_hi;
			b_hi_q <= b_hi;
		end
	end

	// row sums over the clipped part of the window
	logic [ROW_W-1:0] rsum [3][3];
	logic [DIV_W-1:0] gen_div;
	logic [POS_W-1:0] gen_row, gen_col;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int ch = 0; ch < 3; ch++) begin
				rsum[k][ch] = '0;
				for (int w = 0; w < 3; w++) begin
					if ((a_q <= 2'(k)) && (b_q <= 2'(w))) begin
						rsum[k][ch] = rsum[k][ch] + ROW_W'(win_q[k][w][ch]);
					end
				end
			end
		end
		gen_div = DIV_W'(2'd3 - a_q) * DIV_W'(2'd3 - b_q);
		gen_row = row2_q + POS_W'(a_q) - POS_W'(2);
		gen_col = col2_q + POS_W'(b_q) - POS_W'(2);
	end

	// ------------------------------------------------------------------
	// Stages 3 to 5: sum, reciprocal multiply, correction
	// ------------------------------------------------------------------
	logic                 v3_q, v4_q, v5_q;
	logic [ROW_W-1:0]     rsum_s3 [3][3];
	logic [SUM_W-1:0]     total_s4 [3], total_s5 [3], q0_s5 [3];
	logic [DIV_W-1:0]     div_s3, div_s4, div_s5;
	logic [POS_OUT_W-1:0] orow_s3, ocol_s3, orow_s4, ocol_s4, orow_s5, ocol_s5;
	logic                 last_s3, last_s4, last_s5;
	logic [PROD_W-1:0]    prod [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			v3_q <= issue;
			v4_q <= v3_q;
			v5_q <= v4_q;
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			prod[ch] = PROD_W'(total_s4[ch]) * PROD_W'(recip(div_s4));
		end
	end

	always_ff @(posedge clk) begin
		rsum_s3 <= rsum;
		div_s3  <= gen_div;
		orow_s3 <= POS_OUT_W'(gen_row);
		ocol_s3 <= POS_OUT_W'(gen_col);
		last_s3 <= gen_last;
		for (int ch = 0; ch < 3; ch++) begin
			total_s4[ch] <= SUM_W'(rsum_s3[0][ch]) + SUM_W'(rsum_s3[1][ch])
				+ SUM_W'(rsum_s3[2][ch]);
			q0_s5[ch]    <= SUM_W'(prod[ch] >> RECIP_SHIFT);
		end
		div_s4   <= div_s3;
		orow_s4  <= orow_s3;
		ocol_s4  <= ocol_s3;
		last_s4  <= last_s3;
		total_s5 <= total_s4;
		div_s5   <= div_s4;
		orow_s5  <= orow_s4;
		ocol_s5  <= ocol_s4;
		last_s5  <= last_s4;
	end

	// estimate is the quotient or one short of it
	logic [SUM_W-1:0] rem [3], quot [3];
	pix_out_t         res_new;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			rem[ch]  = total_s5[ch] - SUM_W'(q0_s5[ch] * SUM_W'(div_s5));
			quot[ch] = (rem[ch] >= SUM_W'(div_s5)) ? q0_s5[ch] + SUM_W'(1) : q0_s5[ch];
		end
		res_new.out_red     = CH_W'(quot[0]);
		res_new.out_green   = CH_W'(quot[1]);
		res_new.out_blue    = CH_W'(quot[2]);
		res_new.out_row     = orow_s5;
		res_new.out_col     = ocol_s5;
		res_new.last_of_run = last_s5;
	end

	// ------------------------------------------------------------------
	// Result queue; occ_q counts results issued and not yet transferred
	// ------------------------------------------------------------------
	pix_out_t          q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] q_cnt_q, inflight_cnt;
	logic              pop;

	assign res_valid    = (q_cnt_q != '0);
	assign res          = q_mem[rd_ptr_q];
	assign pop          = res_valid && res_ready;
	assign inflight_cnt = QCNT_W'(v3_q) + QCNT_W'(v4_q) + QCNT_W'(v5_q);

	always_ff @(posedge clk) begin
		if (v5_q) begin
			q_mem[wr_ptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
			occ_q    <= '0;
		end else begin
			if (v5_q) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			q_cnt_q <= q_cnt_q + QCNT_W'(v5_q) - QCNT_W'(pop);
			occ_q   <= occ_q + QCNT_W'(issue) - QCNT_W'(pop);
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`BB3C_ASSERT_ALWAYS(a_credit_match, occ_q == q_cnt_q + inflight_cnt, "credit count lost track of results")
	`BB3C_ASSERT_ALWAYS(a_gen_range, !gen_busy_q || (a_q <= a_hi_q && b_q <= b_hi_q && b_q >= b_lo_q), "generator offset out of range")
	`BB3C_ASSERT_NEXT(a_gen_done, issue && gen_last && !advance, !gen_busy_q, "generator busy after its last result")

endmodule

@@ dv/box_blur_3x3_clipped_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_clipped_tb
// Self-checking bench for the streaming clipped 3x3 box blur. Pixels are
// streamed in raster order under random source gaps and sink stalls. A
// three-row image ring in the bench predicts every blurred pixel, its
// coordinates and the end-of-burst flag, and each result transfer is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module box_blur_3x3_clipped_tb;
	import bb3c_pkg::*;

	localparam int LATENCY     = 5;
	localparam int SETTLE      = LATENCY + 5;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int RANDOM_PIX  = 130;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              pix_valid = 1'b0;
	logic              pix_ready;
	pix_in_t           pix       = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	pix_out_t          res;
	logic              cfg_we    = 1'b0;
	logic [SIZE_W-1:0] cfg_wdata = '0;

	// Bench-side copy of the block state
	int                img_size = SIZE_RESET;
	int                next_row = 0;
	int                next_col = 0;
	pix_in_t           row_ring [3][MAX_SIZE_DEF];
	pix_out_t          expected_results [$];

	// Traffic shaping
	bit                tx_idle   = 1'b0;
	bit                rx_idle   = 1'b0;
	int                hold_reqs = 0;
	int                hold_seen = 0;
	int                hold_left = 0;
	int                run_left  = 0;

	int                n_errors    = 0;
	int                cycle_count = 0;

	box_blur_3x3_clipped u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Sink: runs of ready and stall, plus requested long hold-offs
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_ready <= 1'b0;
		end else if (!rx_idle) begin
			res_ready <= 1'b1;
		end else if (run_left > 0) begin
			run_left = run_left - 1;
		end else if ($urandom_range(0, 99) < 65) begin
			res_ready <= 1'b1;
			run_left = $urandom_range(0, 7);
		end else begin
			res_ready <= 1'b0;
			run_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
				: $urandom_range(10, 30);
		end
	end

	task automatic check_field(input string what, input logic [CH_W-1:0] want,
			input logic [CH_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what,
				want, got);
			n_errors++;
		end
	endtask

	// Result checker: every result transfer against the oldest prediction
	always @(posedge clk) begin : result_check
		pix_out_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual row %0d col %0d",
					$time, res.out_row, res.out_col);
				n_errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("out_red",     want.out_red,     res.out_red);
				check_field("out_green",   want.out_green,   res.out_green);
				check_field("out_blue",    want.out_blue,    res.out_blue);
				check_field("out_row",     CH_W'(want.out_row),     CH_W'(res.out_row));
				check_field("out_col",     CH_W'(want.out_col),     CH_W'(res.out_col));
				check_field("last_of_run", CH_W'(want.last_of_run), CH_W'(res.last_of_run));
			end
		end
	end

	// Predict the blurred pixels closed by one pixel transfer
	function automatic void predict_pixel(input pix_in_t px);
		int          n, r, c, ilo, ihi, jlo, jhi, y, x;
		int unsigned sum_r, sum_g, sum_b, cnt;
		pix_out_t    o;
		n = img_size;
		r = next_row;
		c = next_col;
		row_ring[r % 3][c] = px;
		ilo = (r < 2) ? 0 : r - 2;
		ihi = (r == n - 1) ? r : r - 2;
		jlo = (c < 2) ? 0 : c - 2;
		jhi = (c == n - 1) ? c : c - 2;
		for (int i = ilo; i <= ihi; i++) begin
			for (int j = jlo; j <= jhi; j++) begin
				sum_r = 0;
				sum_g = 0;
				sum_b = 0;
				cnt   = 0;
				for (int di = 0; di < 3; di++) begin
					for (int dj = 0; dj < 3; dj++) begin
						y = i + di;
						x = j + dj;
						if (y < n && x < n) begin
							cnt++;
							sum_r += row_ring[y % 3][x].in_red;
							sum_g += row_ring[y % 3][x].in_green;
							sum_b += row_ring[y % 3][x].in_blue;
						end
					end
				end
				o.out_red     = CH_W'(sum_r / cnt);
				o.out_green   = CH_W'(sum_g / cnt);
				o.out_blue    = CH_W'(sum_b / cnt);
				o.out_row     = POS_OUT_W'(i);
				o.out_col     = POS_OUT_W'(j);
				o.last_of_run = (i == ihi && j == jhi);
				expected_results.push_back(o);
			end
		end
		// Advance the raster position, wrapping at the end of the image
		if (c >= n - 1) begin
			next_col = 0;
			next_row = (r >= n - 1) ? 0 : r + 1;
		end else begin
			next_col = c + 1;
		end
	endfunction

	function automatic logic [CH_W-1:0] rand_channel();
		int unsigned p;
		p = $urandom_range(0, 7);
		if (p == 0)
			return '0;
		if (p == 1)
			return '1;
		return CH_W'($urandom_range(0, 65535));
	endfunction

	function automatic pix_in_t rand_pixel();
		pix_in_t px;
		px.in_red   = rand_channel();
		px.in_green = rand_channel();
		px.in_blue  = rand_channel();
		return px;
	endfunction

	function automatic int tx_gap();
		int unsigned p;
		if (!tx_idle)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 65)
			return 0;
		if (p < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// One pixel transfer; called and returning on a rising edge
	task automatic send_pixel(input pix_in_t px);
		int gap;
		pix_valid <= 1'b1;
		pix       <= px;
		@(posedge clk);
		while (!pix_ready)
			@(posedge clk);
		predict_pixel(px);
		gap = tx_gap();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_pixels(input int count);
		for (int k = 0; k < count; k++)
			send_pixel(rand_pixel());
		pix_valid <= 1'b0;
	endtask

	// Wait for every predicted result, then for the pipeline to empty
	task automatic drain();
		pix_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		img_size = (value < 1) ? 1 : (value > MAX_SIZE_DEF) ? MAX_SIZE_DEF : int'(value);
		next_row = 0;
		next_col = 0;
	endtask

	// Reset size, full-width rows with the row-end burst
	task automatic test_default_size();
		tx_idle = 1'b0;
		rx_idle <= 1'b1;
		send_random_pixels(3 * MAX_SIZE_DEF);
		drain();
	endtask

	// A size above the maximum clamps to the maximum
	task automatic test_size_clamp_high();
		write_size('1);
		send_random_pixels(2 * MAX_SIZE_DEF + 3);
		drain();
	endtask

	// Size zero acts as one: each pixel is its own result and a whole image
	task automatic test_size_zero();
		pix_in_t px;
		tx_idle = 1'b1;
		write_size('0);
		px = '0;
		send_pixel(px);
		px = '1;
		send_pixel(px);
		px = {16'hFFFF, 16'h0000, 16'h8001};
		send_pixel(px);
		drain();
	endtask

	// 2x2 and 3x3 images: every divisor, the final-pixel burst, full scale
	task automatic test_small_borders();
		write_size(SIZE_W'(2));
		send_random_pixels(4);
		write_size(SIZE_W'(3));
		for (int k = 0; k < 9; k++)
			send_pixel('1);
		pix_valid <= 1'b0;
		drain();
	endtask

	// Size rewritten part-way through an image restarts at pixel (0,0)
	task automatic test_mid_image_restart();
		write_size(SIZE_W'(4));
		send_random_pixels(10);
		write_size(SIZE_W'(3));
		send_random_pixels(9);
		drain();
	endtask

	// Whole images of random small size, some back to back, some cut short
	task automatic test_random_images();
		int sent, n, count;
		sent = 0;
		while (sent < RANDOM_PIX) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle <= ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0)
				write_size('0);
			else
				write_size(SIZE_W'($urandom_range(1, 8)));
			n = img_size;
			count = n * n;
			if ($urandom_range(0, 9) < 3)
				count = 2 * n * n;
			else if ($urandom_range(0, 9) == 0)
				count = $urandom_range(1, n * n);
			send_random_pixels(count);
			sent += count;
		end
		drain();
	endtask

	// Long sink hold-off while the source keeps offering pixels
	task automatic test_output_backpressure();
		tx_idle = 1'b0;
		rx_idle <= 1'b1;
		write_size(SIZE_W'(6));
		hold_reqs <= hold_reqs + 1;
		send_random_pixels(36);
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_size();
		test_size_clamp_high();
		test_size_zero();
		test_small_borders();
		test_mid_image_restart();
		test_random_images();
		test_output_backpressure();
		drain();
		repeat (4 * LATENCY) @(posedge clk);
		if (n_errors == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
